[rtl/core/abps_pkg.sv]
// shared types and constants for the alarm beep pattern sequencer
// no dependencies; imported by every module of the block

package abps_pkg;

  localparam int LEVEL_W   = 2;
  localparam int PATTERN_W = 28;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W     = 8;
  localparam int REP_W     = 4;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THREE = 2'd2;

  // alarm levels
  localparam logic [LEVEL_W-1:0] LEVEL_OFF   = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE = 2'd3;

  // reset patterns
  localparam logic [PATTERN_W-1:0] LEVEL_ONE_RESET   = 28'd70706;
  localparam logic [PATTERN_W-1:0] LEVEL_TWO_RESET   = 28'd21300500;
  localparam logic [PATTERN_W-1:0] LEVEL_THREE_RESET = 28'd11141898;

  // packed pattern word, msb first
  typedef struct packed {
    logic [LEN_W-1:0] rest_len;
    logic [REP_W-1:0] reps;
    logic [LEN_W-1:0] gap_len;
    logic [LEN_W-1:0] on_len;
  } pattern_t;

  typedef enum logic [2:0] {
    PH_ON   = 3'b001,
    PH_GAP  = 3'b010,
    PH_REST = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [LEN_W-1:0] cnt;
    logic [REP_W-1:0] rep;
  } seq_state_t;

endpackage

[rtl/core/abps_cfg_regs.sv]
// per-level pattern registers with write port and level select
// depends on abps_pkg

module abps_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_write_en,
  input  logic [abps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abps_pkg::PATTERN_W-1:0]  cfg_data,
  input  logic [abps_pkg::LEVEL_W-1:0]    sel_level,
  output abps_pkg::pattern_t              sel_pattern
);
  import abps_pkg::*;

  pattern_t lvl_one_r;
  pattern_t lvl_two_r;
  pattern_t lvl_three_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_one_r   <= pattern_t'(LEVEL_ONE_RESET);
      lvl_two_r   <= pattern_t'(LEVEL_TWO_RESET);
      lvl_three_r <= pattern_t'(LEVEL_THREE_RESET);
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_LEVEL_ONE:   lvl_one_r   <= pattern_t'(cfg_data);
        CFG_LEVEL_TWO:   lvl_two_r   <= pattern_t'(cfg_data);
        CFG_LEVEL_THREE: lvl_three_r <= pattern_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // level off reads level three; its output is masked downstream
  always_comb begin
    case (sel_level)
      LEVEL_ONE: sel_pattern = lvl_one_r;
      LEVEL_TWO: sel_pattern = lvl_two_r;
      default:   sel_pattern = lvl_three_r;
    endcase
  end

endmodule

[rtl/core/abps_step.sv]
// one-tick next-state logic: restart, zero-length phase skipping, tick count
// depends on abps_pkg

module abps_step (
  input  logic [abps_pkg::LEVEL_W-1:0] level_req,
  input  logic [abps_pkg::LEVEL_W-1:0] level_cur,
  input  abps_pkg::seq_state_t         state_cur,
  input  abps_pkg::pattern_t           pattern,
  output abps_pkg::seq_state_t         state_nxt,
  output logic                         buzz
);
  import abps_pkg::*;

  function automatic logic is_last(input logic [REP_W-1:0] r, input logic [REP_W-1:0] reps);
    return ({1'b0, r} + {{REP_W{1'b0}}, 1'b1}) >= {1'b0, reps};
  endfunction

  function automatic logic [LEN_W-1:0] phase_len(input phase_t ph, input pattern_t p);
    logic [LEN_W-1:0] len;
    case (ph)
      PH_ON:   len = p.on_len;
      PH_GAP:  len = p.gap_len;
      default: len = p.rest_len;
    endcase
    return len;
  endfunction

  // enter the on phase of repeat r and skip empty phases
  function automatic seq_state_t from_on(input logic [REP_W-1:0] r, input pattern_t p,
                                         input logic [REP_W-1:0] reps);
    seq_state_t s;
    s.cnt = '0;
    s.rep = r;
    if (p.on_len != '0) begin
      s.phase = PH_ON;
    end else if (p.gap_len != '0) begin
      s.phase = PH_GAP;
    end else begin
      s.phase = PH_REST;
      if (!is_last(r, reps)) s.rep = reps - {{(REP_W-1){1'b0}}, 1'b1};
    end
    return s;
  endfunction

  // leave a gap and skip empty phases
  function automatic seq_state_t exit_gap(input logic [REP_W-1:0] r, input pattern_t p,
                                          input logic [REP_W-1:0] reps);
    seq_state_t s;
    if (is_last(r, reps)) begin
      if (p.rest_len != '0) begin
        s.phase = PH_REST;
        s.cnt   = '0;
        s.rep   = r;
      end else begin
        s = from_on('0, p, reps);
      end
    end else begin
      s = from_on(r + {{(REP_W-1){1'b0}}, 1'b1}, p, reps);
    end
    return s;
  endfunction

  logic [REP_W-1:0] reps_eff;
  logic             all_zero;
  seq_state_t       base;
  seq_state_t       settled;
  logic [LEN_W-1:0] settled_len;
  logic [LEN_W-1:0] cnt_inc;

  assign reps_eff = (pattern.reps == '0) ? {{(REP_W-1){1'b0}}, 1'b1} : pattern.reps;
  assign all_zero = (pattern.on_len == '0) && (pattern.gap_len == '0) &&
                    (pattern.rest_len == '0);

  always_comb begin
    // a level change restarts at the first on phase
    if (level_req != level_cur) begin
      base.phase = PH_ON;
      base.cnt   = '0;
      base.rep   = '0;
    end else begin
      base = state_cur;
    end

    // settle on a phase with ticks left
    if (base.cnt < phase_len(base.phase, pattern)) begin
      settled = base;
    end else begin
      case (base.phase)
        PH_ON: begin
          if (pattern.gap_len != '0) begin
            settled.phase = PH_GAP;
            settled.cnt   = '0;
            settled.rep   = base.rep;
          end else begin
            settled = exit_gap(base.rep, pattern, reps_eff);
          end
        end
        PH_GAP:  settled = exit_gap(base.rep, pattern, reps_eff);
        default: settled = from_on('0, pattern, reps_eff);
      endcase
    end

    settled_len = phase_len(settled.phase, pattern);
    cnt_inc     = settled.cnt + {{(LEN_W-1){1'b0}}, 1'b1};

    state_nxt = base;
    buzz      = 1'b0;
    if (level_req != LEVEL_OFF) begin
      if (all_zero) begin
        state_nxt.phase = PH_ON;
        state_nxt.cnt   = '0;
        state_nxt.rep   = '0;
      end else begin
        buzz = (settled.phase == PH_ON);
        if (cnt_inc >= settled_len) begin
          // single phase step, no skipping until the next tick
          state_nxt.cnt = '0;
          state_nxt.rep = settled.rep;
          case (settled.phase)
            PH_ON: state_nxt.phase = PH_GAP;
            PH_GAP: begin
              if (is_last(settled.rep, reps_eff)) begin
                state_nxt.phase = PH_REST;
              end else begin
                state_nxt.phase = PH_ON;
                state_nxt.rep   = settled.rep + {{(REP_W-1){1'b0}}, 1'b1};
              end
            end
            default: begin
              state_nxt.phase = PH_ON;
              state_nxt.rep   = '0;
            end
          endcase
        end else begin
          state_nxt     = settled;
          state_nxt.cnt = cnt_inc;
        end
      end
    end
  end

endmodule

[rtl/core/alarm_beep_pattern_sequencer.sv]
// top level of the alarm beep pattern sequencer: input register, step logic, result register
// depends on abps_pkg, abps_cfg_regs and abps_step

// Each input beat is one 100 ms tick carrying the requested alarm level; each
// tick yields exactly one result beat with the buzzer state and the running
// level. The block takes one beat per clock cycle when the output side keeps
// up. An accepted tick is held in the input register; a single pass through
// the step logic (phase select, zero-length phase skipping and the 8-bit
// tick compare) then loads the result register, which offers the result
// beat. While the result is stalled the tick waits in the input register.
// Level 0 keeps the buzzer silent; a
// level change restarts the new pattern at its first on phase within the same
// tick. Pattern registers are written through cfg_write_en / cfg_index /
// cfg_data and take effect on the next tick; write them only while idle.
// There is no memory and no clearing pass after reset.

module alarm_beep_pattern_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  // tick channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [abps_pkg::LEVEL_W-1:0]    in_level_request,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_buzzer_drive,
  output logic [abps_pkg::LEVEL_W-1:0]    out_level_active,
  // configuration write port
  input  logic                            cfg_write_en,
  input  logic [abps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abps_pkg::PATTERN_W-1:0]  cfg_data
);
  import abps_pkg::*;

  // input register
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic [LEVEL_W-1:0] s1_level_r;

  // sequencer state
  seq_state_t         state_r;
  seq_state_t         state_nxt;
  logic [LEVEL_W-1:0] level_r;

  // result register
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_buzz_r;
  logic [LEVEL_W-1:0] out_level_r;

  logic               pipe_adv;
  logic               step_fire;
  logic               in_fire;
  logic               buzz;
  pattern_t           sel_pattern;

  // pipeline moves whenever the result slot is free or being drained
  assign pipe_adv  = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || pipe_adv;
  assign in_fire   = in_valid && in_ready;
  assign step_fire = s1_valid_r && pipe_adv;

  // pattern of the requested level
  abps_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sel_level    (s1_level_r),
    .sel_pattern  (sel_pattern)
  );

  // next state and buzzer for the tick held in the input register
  abps_step u_step (
    .level_req (s1_level_r),
    .level_cur (level_r),
    .state_cur (state_r),
    .pattern   (sel_pattern),
    .state_nxt (state_nxt),
    .buzz      (buzz)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (step_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      level_r       <= LEVEL_OFF;
      state_r.phase <= PH_ON;
      state_r.cnt   <= '0;
      state_r.rep   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step_fire) begin
        level_r <= s1_level_r;
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_level_r <= in_level_request;
    end
    if (step_fire) begin
      out_buzz_r  <= buzz;
      out_level_r <= s1_level_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_buzzer_drive = out_buzz_r;
  assign out_level_active = out_level_r;

  // a silent level never sounds
  a_off_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_level_r == LEVEL_OFF) |-> !out_buzz_r)
    else $error("buzzer driven while level is off");

  // repeat index stays below the largest repeat count
  a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.rep != {REP_W{1'b1}})
    else $error("repeat index out of range");

  // tick count never reaches the top of its range
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.cnt != {LEN_W{1'b1}})
    else $error("phase tick count out of range");

  // a computed tick lands in the result register with its level
  a_result_level: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire |=> out_valid_r && (out_level_r == $past(s1_level_r)) &&
                  (level_r == $past(s1_level_r)))
    else $error("result level does not follow the tick");

  // a stalled result keeps the input register from being overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !pipe_adv |=> s1_valid_r && $stable(s1_level_r))
    else $error("input register overwritten while stalled");

endmodule
